@@ rtl/assert_macros.svh @@
// Assertion macros used by the back stage of the radix digit converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

@@ rtl/itrd_pkg.sv @@
// Package with the shared types and constants of the radix digit converter.
`timescale 1ns / 1ps

package itrd_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAX_RADIX       = 16;
  localparam int IN_VALUE_W      = 64;
  localparam int RADIX_W         = 5;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 7;
  localparam int POLICY_W        = 2;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int QUEUE_DEPTH     = 2;
  localparam int BITS_PER_CYCLE  = 8;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(MAX_RADIX);
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [POLICY_W-1:0] POLICY_NEGATIVE = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_ALWAYS   = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_NONZERO  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               negative;
    logic               shown;
  } job_ctl_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              sign_shown;
    logic [CHAR_W-1:0] sign_char;
    logic [LEN_W-1:0]  length;
  } result_t;

endpackage

@@ rtl/itrd_fifo.sv @@
// Small first-in first-out queue used between the converter stages.
`timescale 1ns / 1ps

module itrd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/itrd_front.sv @@
// Front stage: takes the magnitude, sign and radix decisions for each transaction.
`timescale 1ns / 1ps

module itrd_front #(
  parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            op,
  input  logic [itrd_pkg::IN_VALUE_W-1:0] value,
  input  logic [itrd_pkg::POLICY_W-1:0]   sign_policy,
  input  logic [itrd_pkg::RADIX_W-1:0]    radix,
  output logic [VALUE_WIDTH-1:0]          mag,
  output itrd_pkg::job_ctl_t              ctl
);

  import itrd_pkg::*;

  logic [VALUE_WIDTH-1:0] raw;
  logic                   negative;

  assign raw      = value[VALUE_WIDTH-1:0];
  assign negative = op && raw[VALUE_WIDTH-1];
  assign mag      = negative ? (~raw + 1'b1) : raw;

  always_comb begin
    if (radix < RADIX_MIN) begin
      ctl.radix = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      ctl.radix = RADIX_MAX;
    end else begin
      ctl.radix = radix;
    end
    ctl.negative = negative;
    ctl.shown    = negative || (sign_policy == POLICY_ALWAYS) ||
                   ((sign_policy == POLICY_NONZERO) && (raw != '0));
  end

endmodule

@@ rtl/itrd_back.sv @@
// Back stage: restoring divider that produces one digit per pass and builds results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itrd_back #(
  parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_empty,
  input  logic [VALUE_WIDTH-1:0]          job_mag,
  input  itrd_pkg::job_ctl_t              job_ctl,
  output logic                            job_pop,
  input  logic [itrd_pkg::CFG_DATA_W-1:0] symbols_low,
  input  logic [itrd_pkg::CFG_DATA_W-1:0] symbols_high,
  input  logic                            out_full,
  output logic                            out_push,
  output itrd_pkg::result_t               out_item
);

  import itrd_pkg::*;

  localparam int CHUNKS = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int PAD_W  = CHUNKS * BITS_PER_CYCLE;
  localparam int STEP_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t               state;
  logic [PAD_W-1:0]     dividend;
  logic [DIGIT_W-1:0]   rem;
  logic [STEP_W-1:0]    step;
  logic [LEN_W-1:0]     count;
  logic [RADIX_W-1:0]   radix_q;
  logic                 negative;
  logic                 shown;

  logic [PAD_W-1:0]     div_next;
  logic [DIGIT_W-1:0]   rem_next;
  logic [RADIX_W-1:0]   trial;
  logic [CFG_DATA_W-1:0] sym_word;
  logic                 is_last;

  always_comb begin
    div_next = dividend;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial    = {rem_next, div_next[PAD_W-1]};
      div_next = {div_next[PAD_W-2:0], 1'b0};
      if (trial >= radix_q) begin
        rem_next    = DIGIT_W'(trial - radix_q);
        div_next[0] = 1'b1;
      end else begin
        rem_next = trial[DIGIT_W-1:0];
      end
    end
  end

  assign job_pop  = (state == S_IDLE) && !job_empty;
  assign out_push = (state == S_EMIT) && !out_full;
  assign is_last  = (dividend == '0);
  assign sym_word = rem[DIGIT_W-1] ? symbols_high : symbols_low;

  always_comb begin
    out_item.char_code  = sym_word[{rem[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    out_item.last       = is_last;
    out_item.sign_shown = is_last && shown;
    out_item.sign_char  = !is_last ? '0 : (negative ? CHAR_MINUS : CHAR_PLUS);
    out_item.length     = is_last ? (count + LEN_W'(shown)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!job_empty) begin
            dividend <= PAD_W'(job_mag);
            radix_q  <= job_ctl.radix;
            negative <= job_ctl.negative;
            shown    <= job_ctl.shown;
            rem      <= '0;
            step     <= '0;
            count    <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          dividend <= div_next;
          rem      <= rem_next;
          if (step == STEP_W'(CHUNKS - 1)) begin
            count <= count + 1'b1;
            state <= S_EMIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_full) begin
            rem  <= '0;
            step <= '0;
            state <= is_last ? S_IDLE : S_DIV;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMP(a_digit_below_radix, clk, rst, state == S_EMIT, {1'b0, rem} < radix_q)
  `ASSERT_NEXT(a_last_ends_run, clk, rst, out_push && out_item.last, state == S_IDLE)
  `ASSERT_NEXT(a_load_starts_div, clk, rst, job_pop, state == S_DIV && step == '0)
  `ASSERT_IMP(a_count_bound, clk, rst, state != S_IDLE, count <= LEN_W'(VALUE_WIDTH))

endmodule

@@ rtl/integer_to_radix_digits.sv @@
// Top level of the integer to radix digit converter.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------------
//   input    | push / full          | op, value, sign_policy
//   results  | pop / empty          | char_code, last, sign_shown, sign_char, length
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// For each digit the restoring divider retires 8 quotient bits per cycle across the padded
// value, then the emit state hands the digit to the result queue.
// Each item is first loaded from the job queue, then divided and emitted digit by digit.
// Reset is synchronous; it empties both queues, sets radix to 10 and symbols to 0.
// A two-entry job queue takes items while the divider works; full rises when it fills.
// A two-entry result queue decouples pop; the divider holds each finished digit while that queue is full.
`timescale 1ns / 1ps

module integer_to_radix_digits #(
  parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             op,
  input  logic [itrd_pkg::IN_VALUE_W-1:0]  value,
  input  logic [itrd_pkg::POLICY_W-1:0]    sign_policy,
  output logic                             empty,
  input  logic                             pop,
  output logic [itrd_pkg::CHAR_W-1:0]      char_code,
  output logic                             last,
  output logic                             sign_shown,
  output logic [itrd_pkg::CHAR_W-1:0]      sign_char,
  output logic [itrd_pkg::LEN_W-1:0]       length,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [itrd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import itrd_pkg::*;

  localparam int JOB_W = VALUE_WIDTH + $bits(job_ctl_t);
  localparam int RES_W = $bits(result_t);

  logic [RADIX_W-1:0]    radix;
  logic [CFG_DATA_W-1:0] symbols_low;
  logic [CFG_DATA_W-1:0] symbols_high;

  logic [VALUE_WIDTH-1:0] front_mag;
  job_ctl_t               front_ctl;
  logic [JOB_W-1:0]       job_rd;
  logic                   job_empty;
  logic                   job_pop;
  logic [VALUE_WIDTH-1:0] job_mag;
  job_ctl_t               job_ctl;

  logic                   out_push;
  logic                   out_full;
  result_t                out_item;
  logic [RES_W-1:0]       res_rd;
  result_t                res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= RADIX_RESET;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIX:        radix        <= cfg_data[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  itrd_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .op          (op),
    .value       (value),
    .sign_policy (sign_policy),
    .radix       (radix),
    .mag         (front_mag),
    .ctl         (front_ctl)
  );

  itrd_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_job_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data ({front_mag, front_ctl}),
    .full    (full),
    .rd_en   (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  assign job_mag = job_rd[JOB_W-1 -: VALUE_WIDTH];
  assign job_ctl = job_ctl_t'(job_rd[$bits(job_ctl_t)-1:0]);

  itrd_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_empty    (job_empty),
    .job_mag      (job_mag),
    .job_ctl      (job_ctl),
    .job_pop      (job_pop),
    .symbols_low  (symbols_low),
    .symbols_high (symbols_high),
    .out_full     (out_full),
    .out_push     (out_push),
    .out_item     (out_item)
  );

  itrd_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_item),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign res        = result_t'(res_rd);
  assign char_code  = res.char_code;
  assign last       = res.last;
  assign sign_shown = res.sign_shown;
  assign sign_char  = res.sign_char;
  assign length     = res.length;

endmodule
